// ===== rtl/lhbp_pkg.sv =====
package lhbp_pkg;

  localparam int PC_BITS      = 10;
  localparam int HISTORY_BITS = 10;
  localparam int PC_W         = 10;
  localparam int CTR_W        = 3;

  localparam int HIST_DEPTH = 1 << PC_BITS;
  localparam int CTR_DEPTH  = 1 << HISTORY_BITS;
  localparam int CLR_BITS   = (PC_BITS > HISTORY_BITS) ? PC_BITS : HISTORY_BITS;

  localparam logic [CTR_W-1:0] CTR_MAX     = 3'd7;
  localparam logic [CTR_W-1:0] CTR_MIN     = 3'd0;
  localparam logic [CTR_W-1:0] CTR_INIT    = 3'd3;
  localparam logic [CTR_W-1:0] TAKEN_ABOVE = 3'd3;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic clearing;
    logic hist_stage;
    logic ctr_stage;
    logic out_load;
  } ctrl_t;

  function automatic logic [PC_BITS-1:0] pc_slot(input logic [PC_W-1:0] pc);
    logic [PC_W+PC_BITS-1:0] ext;
    ext = {{PC_BITS{1'b0}}, pc};
    return ext[PC_BITS-1:0];
  endfunction

  function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] ctr,
                                                input logic taken);
    logic [CTR_W-1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/lhbp_if.sv =====
interface lhbp_in_if;
  import lhbp_pkg::*;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [PC_W-1:0] pc_index;
  logic            taken;

  modport source(output valid, operation, pc_index, taken, input ready);
  modport sink(input valid, operation, pc_index, taken, output ready);
endinterface

interface lhbp_out_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source(output valid, predict_taken, input ready);
  modport sink(input valid, predict_taken, output ready);
endinterface

// ===== rtl/lhbp_ram.sv =====
module lhbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lhbp_ctrl.sv =====
module lhbp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     out_free,
  output lhbp_pkg::ctrl_t          ctrl,
  output logic [lhbp_pkg::CLR_BITS-1:0] clr_idx
);
  import lhbp_pkg::*;

  state_t              state_r, state_nxt;
  logic [CLR_BITS-1:0] clr_idx_r, clr_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CLR_BITS'(1);
        if (clr_idx_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HIST;
      end
      ST_HIST: state_nxt = ST_CTR;
      ST_CTR:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_CLEAR: ctrl.clearing   = 1'b1;
      ST_IDLE:  ctrl.in_rdy     = 1'b1;
      ST_HIST:  ctrl.hist_stage = 1'b1;
      ST_CTR:   ctrl.ctr_stage  = 1'b1;
      ST_OUT:   ctrl.out_load   = out_free;
      default:  ctrl = '0;
    endcase
  end

  assign clr_idx = clr_idx_r;

endmodule

// ===== rtl/local_history_branch_predictor_unit.sv =====
// channel | dir | fields                              | handshake
// in_ch   | in  | operation, pc_index[9:0], taken     | valid/ready
// out_ch  | out | predict_taken                       | valid/ready
//
// an item passes through accept, history ram read, counter ram read and
// write back, then result register load; one item is in flight at a time
// after reset a clearing pass over 2^max(PC_BITS, HISTORY_BITS) = 1024
// addresses fills both rams before the first word is accepted
// a stalled result holds the item in the load step until out_ch.ready
module local_history_branch_predictor_unit (
  input  logic          clk,
  input  logic          rst_n,
  lhbp_in_if.sink       in_ch,
  lhbp_out_if.source    out_ch
);
  import lhbp_pkg::*;

  ctrl_t                   ctrl;
  logic [CLR_BITS-1:0]     clr_idx;
  logic                    accept;
  logic                    out_free;

  op_t                     op_r;
  logic                    taken_r;
  logic [PC_BITS-1:0]      slot_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic                    pred_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_pred_r;

  logic                    upd_we;
  logic                    hist_we, ctr_we;
  logic [PC_BITS-1:0]      hist_waddr;
  logic [HISTORY_BITS-1:0] hist_wdata, hist_rdata;
  logic [HISTORY_BITS-1:0] ctr_waddr;
  logic [CTR_W-1:0]        ctr_wdata, ctr_rdata;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = ctrl.in_rdy && in_ch.valid;

  lhbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .clr_idx  (clr_idx)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_ch.operation);
      taken_r <= in_ch.taken;
      slot_r  <= pc_slot(in_ch.pc_index);
    end
    if (ctrl.hist_stage) hist_r <= hist_rdata;
    if (ctrl.ctr_stage)  pred_r <= (ctr_rdata > TAKEN_ABOVE);
    if (ctrl.out_load)   out_pred_r <= pred_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // clearing pass writes reset values, otherwise an update writes back
  assign upd_we = ctrl.ctr_stage && (op_r == OP_UPDATE);

  always_comb begin
    if (ctrl.clearing) begin
      hist_we    = ((clr_idx >> PC_BITS) == '0);
      hist_waddr = clr_idx[PC_BITS-1:0];
      hist_wdata = '0;
      ctr_we     = ((clr_idx >> HISTORY_BITS) == '0);
      ctr_waddr  = clr_idx[HISTORY_BITS-1:0];
      ctr_wdata  = CTR_INIT;
    end else begin
      hist_we    = upd_we;
      hist_waddr = slot_r;
      hist_wdata = HISTORY_BITS'({hist_r, taken_r});
      ctr_we     = upd_we;
      ctr_waddr  = hist_r;
      ctr_wdata  = ctr_step(ctr_rdata, taken_r);
    end
  end

  lhbp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (pc_slot(in_ch.pc_index)),
    .rdata (hist_rdata)
  );

  lhbp_ram #(.WIDTH(CTR_W), .DEPTH(CTR_DEPTH)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (hist_rdata),
    .rdata (ctr_rdata)
  );

  assign in_ch.ready          = ctrl.in_rdy;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.predict_taken = out_pred_r;

`ifndef ASSERT_OFF
  a_accept_to_hist: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctrl.hist_stage)
    else $error("accepted word did not reach history read");

  a_hist_to_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.hist_stage |=> ctrl.ctr_stage)
    else $error("history read not followed by counter read");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.out_load))
    else $error("result valid without a load step");
`endif

endmodule

// ===== sim/lhbp_prediction_monitor.sv =====
`timescale 1ns / 100ps

module lhbp_prediction_monitor (
  input  logic        clk,
  input  logic        rst_n,
  lhbp_in_if          in_ch,
  lhbp_out_if         out_ch,
  output int unsigned pending_words,
  output int unsigned mismatches
);
  import lhbp_pkg::*;

  logic [HISTORY_BITS-1:0] branch_hist [HIST_DEPTH];
  logic [CTR_W-1:0]        pattern_ctr [CTR_DEPTH];
  logic                    expected_taken_q [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // returns the prediction read before the item changes anything
  function automatic logic predict_and_train(input op_t op, input logic [PC_W-1:0] pc,
                                             input logic tk);
    logic [PC_BITS-1:0]      slot;
    logic [HISTORY_BITS-1:0] hist;
    logic [CTR_W-1:0]        ctr;
    logic                    guess;
    slot  = PC_BITS'(pc);
    hist  = branch_hist[slot];
    ctr   = pattern_ctr[hist];
    guess = (ctr > TAKEN_ABOVE);
    if (op == OP_UPDATE) begin
      if (tk) begin
        if (ctr != CTR_MAX) ctr = ctr + CTR_W'(1);
      end else begin
        if (ctr != CTR_MIN) ctr = ctr - CTR_W'(1);
      end
      pattern_ctr[hist] = ctr;
      branch_hist[slot] = HISTORY_BITS'({hist, tk});
    end
    return guess;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) branch_hist[i] = '0;
      for (int i = 0; i < CTR_DEPTH; i++) pattern_ctr[i] = CTR_INIT;
      expected_taken_q.delete();
      mismatches = 0;
      pending_words <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_taken_q.push_back(predict_and_train(op_t'(in_ch.operation),
                                                     in_ch.pc_index, in_ch.taken));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_taken_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = expected_taken_q.pop_front();
          if (out_ch.predict_taken !== want)
            report($sformatf("predict_taken %0b, expected %0b", out_ch.predict_taken, want));
        end
      end
      pending_words <= expected_taken_q.size();
    end
  end

endmodule

// ===== sim/local_history_branch_predictor_unit_tb.sv =====
`timescale 1ns / 100ps

module local_history_branch_predictor_unit_tb;
  import lhbp_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_WORDS  = 150;

  logic        clk;
  logic        rst_n;
  int unsigned pending_words;
  int unsigned mismatches;
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned quiet_cycles = 0;
  logic [PC_W-1:0] hot_pc [8];

  lhbp_in_if  in_ch ();
  lhbp_out_if out_ch ();

  local_history_branch_predictor_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lhbp_prediction_monitor i_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .pending_words (pending_words),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic [PC_W-1:0] pc, input logic tk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.pc_index  <= pc;
    in_ch.taken     <= tk;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned src_pct, input int unsigned dst_pct);
    op_t             op;
    logic [PC_W-1:0] pc;
    logic            tk;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      op = ($urandom_range(99) < 60) ? OP_UPDATE : OP_LOOKUP;
      // mostly a few recurring branches so the counters get trained
      if ($urandom_range(99) < 70) begin
        pc = hot_pc[$urandom_range(7)];
        tk = ($urandom_range(99) < (pc[0] ? 85 : 15));
      end else begin
        pc = PC_W'($urandom);
        tk = 1'($urandom_range(1));
      end
      send_word(op, pc, tk);
    end
    drain_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_LOOKUP;
    in_ch.pc_index  = '0;
    in_ch.taken     = 1'b0;
    src_idle_pct    = 32;
    dst_idle_pct    = 82;
    foreach (hot_pc[i]) hot_pc[i] = PC_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, lookup ignoring taken
    send_word(OP_LOOKUP, '0, 1'b1);
    send_word(OP_LOOKUP, '1, 1'b0);
    send_word(OP_LOOKUP, PC_W'(10'h2aa), 1'b1);
    send_word(OP_LOOKUP, PC_W'(10'h155), 1'b0);
    // counter saturation at zero, history stays zero
    repeat (5) send_word(OP_UPDATE, '0, 1'b0);
    send_word(OP_LOOKUP, '0, 1'b1);
    // history fills with ones, then counter saturates at seven
    repeat (15) send_word(OP_UPDATE, '1, 1'b1);
    send_word(OP_LOOKUP, '1, 1'b0);
    drain_results();

    random_phase(32, 82);
    random_phase(82, 32);
    random_phase(0, 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
